>>> rtl/chbd_pkg.sv
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int LIMIT_BITS = 32;
    // Width used to compare the running size against the limit register.
    localparam int CMP_BITS   = (SIZE_BITS > LIMIT_BITS) ? SIZE_BITS : LIMIT_BITS;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = {LIMIT_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_SIZE    = 4'd0,
        PH_SIZE_LF = 4'd1,
        PH_DATA    = 4'd2,
        PH_DATA_CR = 4'd3,
        PH_DATA_LF = 4'd4,
        PH_LAST_CR = 4'd5,
        PH_LAST_LF = 4'd6,
        PH_IDLE    = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CAUSE_HEX   = 2'd0,
        CAUSE_EMPTY = 2'd1,
        CAUSE_CRLF  = 2'd2,
        CAUSE_LARGE = 2'd3
    } cause_t;

    typedef struct packed {
        logic       sob;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        kind_t      kind;
        cause_t     cause;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r.value = 4'(c - 8'h37);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/chbd_in_stage.sv
// ----------------------------------------------------------------------------
// chbd_in_stage
// Input register that holds one accepted body byte until the parser takes it.
// ----------------------------------------------------------------------------
module chbd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  chbd_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output chbd_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    chbd_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

>>> rtl/chbd_parser.sv
// ----------------------------------------------------------------------------
// chbd_parser
// Framing state, size accumulator and limit register; decides the result of
// the byte held in the input register.
// ----------------------------------------------------------------------------
module chbd_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [chbd_pkg::LIMIT_BITS-1:0] cfg_wdata,
    input  logic                            advance,
    input  chbd_pkg::in_item_t              item,
    output chbd_pkg::result_t               result
);

    chbd_pkg::phase_t               phase_reg;
    chbd_pkg::phase_t               phase_next;
    logic [chbd_pkg::SIZE_BITS-1:0] left_reg;
    logic [chbd_pkg::SIZE_BITS-1:0] left_next;
    logic                           seen_reg;
    logic                           seen_next;
    logic [chbd_pkg::LIMIT_BITS-1:0] limit_reg;

    chbd_pkg::phase_t               cur_phase;
    logic [chbd_pkg::SIZE_BITS-1:0] cur_left;
    logic                           cur_seen;
    chbd_pkg::hex_t                 hex;
    logic [chbd_pkg::SIZE_BITS-1:0] shifted;
    logic [chbd_pkg::SIZE_BITS-1:0] decrement;
    logic                           overflow;
    logic                           over_limit;

    // A start-of-body byte sees the freshly reset parser.
    assign cur_phase = item.sob ? chbd_pkg::PH_SIZE : phase_reg;
    assign cur_left  = item.sob ? '0 : left_reg;
    assign cur_seen  = item.sob ? 1'b0 : seen_reg;

    assign hex        = chbd_pkg::hex_decode(item.data);
    assign shifted    = {cur_left[chbd_pkg::SIZE_BITS-5:0], hex.value};
    assign decrement  = cur_left - chbd_pkg::SIZE_BITS'(1);
    assign overflow   = |cur_left[chbd_pkg::SIZE_BITS-1:chbd_pkg::SIZE_BITS-4];
    assign over_limit = chbd_pkg::CMP_BITS'(shifted) > chbd_pkg::CMP_BITS'(limit_reg);

    always_comb
    begin
        phase_next   = cur_phase;
        left_next    = cur_left;
        seen_next    = cur_seen;
        result.valid = 1'b0;
        result.data  = 8'd0;
        result.kind  = chbd_pkg::KIND_ERROR;
        result.cause = chbd_pkg::CAUSE_HEX;

        case (cur_phase)
            chbd_pkg::PH_SIZE:
            begin
                if (item.data == chbd_pkg::CHAR_CR)
                begin
                    if (!cur_seen)
                    begin
                        result.valid = 1'b1;
                        result.cause = chbd_pkg::CAUSE_EMPTY;
                        phase_next   = chbd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = chbd_pkg::PH_SIZE_LF;
                    end
                end
                else if (!hex.ok)
                begin
                    result.valid = 1'b1;
                    result.cause = chbd_pkg::CAUSE_HEX;
                    phase_next   = chbd_pkg::PH_IDLE;
                end
                else if (overflow || over_limit)
                begin
                    // Accumulated value is kept as it was; only the phase moves.
                    result.valid = 1'b1;
                    result.cause = chbd_pkg::CAUSE_LARGE;
                    phase_next   = chbd_pkg::PH_IDLE;
                end
                else
                begin
                    left_next = shifted;
                    seen_next = 1'b1;
                end
            end
            chbd_pkg::PH_SIZE_LF:
            begin
                if (item.data != chbd_pkg::CHAR_LF)
                begin
                    result.valid = 1'b1;
                    result.cause = chbd_pkg::CAUSE_CRLF;
                    phase_next   = chbd_pkg::PH_IDLE;
                end
                else if (cur_left == '0)
                begin
                    phase_next = chbd_pkg::PH_LAST_CR;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_DATA;
                end
            end
            chbd_pkg::PH_DATA:
            begin
                left_next    = decrement;
                result.valid = 1'b1;
                result.data  = item.data;
                result.kind  = chbd_pkg::KIND_PAYLOAD;
                if (decrement == '0)
                begin
                    phase_next = chbd_pkg::PH_DATA_CR;
                end
            end
            chbd_pkg::PH_DATA_CR,
            chbd_pkg::PH_LAST_CR:
            begin
                if (item.data != chbd_pkg::CHAR_CR)
                begin
                    result.valid = 1'b1;
                    result.cause = chbd_pkg::CAUSE_CRLF;
                    phase_next   = chbd_pkg::PH_IDLE;
                end
                else if (cur_phase == chbd_pkg::PH_DATA_CR)
                begin
                    phase_next = chbd_pkg::PH_DATA_LF;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_LAST_LF;
                end
            end
            chbd_pkg::PH_DATA_LF:
            begin
                if (item.data != chbd_pkg::CHAR_LF)
                begin
                    result.valid = 1'b1;
                    result.cause = chbd_pkg::CAUSE_CRLF;
                    phase_next   = chbd_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = chbd_pkg::PH_SIZE;
                    left_next  = '0;
                    seen_next  = 1'b0;
                end
            end
            chbd_pkg::PH_LAST_LF:
            begin
                result.valid = 1'b1;
                phase_next   = chbd_pkg::PH_IDLE;
                if (item.data != chbd_pkg::CHAR_LF)
                begin
                    result.cause = chbd_pkg::CAUSE_CRLF;
                end
                else
                begin
                    result.kind = chbd_pkg::KIND_END;
                end
            end
            default:
            begin
                phase_next = chbd_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= chbd_pkg::PH_SIZE;
            left_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= chbd_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

endmodule

>>> rtl/chbd_out_stage.sv
// ----------------------------------------------------------------------------
// chbd_out_stage
// Result register on the master side; holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module chbd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  chbd_pkg::result_t result,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_data,
    output chbd_pkg::kind_t   m_kind,
    output chbd_pkg::cause_t  m_cause
);

    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       data_reg;
    chbd_pkg::kind_t  kind_reg;
    chbd_pkg::cause_t cause_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;
    assign m_kind   = kind_reg;
    assign m_cause  = cause_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && result.valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.valid)
        begin
            data_reg  <= result.data;
            kind_reg  <= result.kind;
            cause_reg <= result.cause;
        end
    end

endmodule

>>> rtl/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Decodes a chunked message body one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Body bytes enter on the s_axis channel, tuser marking the first byte of a
//   new body. Each input item gives zero or one result on m_axis: a payload
//   byte, an end-of-body mark or a framing error with its cause.
//   The chunk size limit is written through cfg_we/cfg_wdata; the user must
//   write it only while the block is idle: the block does not enforce this.
// Timing:
//   One item per cycle sustained while m_axis_tready is high. The parser
//   decodes the byte held in the input register into the result register
//   when that register can load, with a state update that is a single nibble
//   shift, compare or decrement per byte.
// Reset:
//   rst_n clears both stage valid bits and puts the parser at the start of a
//   size line; the limit returns to its all-ones value.
// Back-pressure:
//   When m_axis_tready is low a pending result stays in the result register;
//   the input register takes one more item only if it is empty, then
//   s_axis_tready drops until the sink resumes.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] body_byte
    input  logic [0:0]                      s_axis_tuser,  // [0] start_of_body
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // [7:0] payload_byte,
                                                           // [9:8] error_cause
    output logic [1:0]                      m_axis_tuser,  // [1:0] result_kind
    input  logic                            cfg_we,
    input  logic [chbd_pkg::LIMIT_BITS-1:0] cfg_wdata
);

    chbd_pkg::in_item_t s_item;
    chbd_pkg::in_item_t item;
    chbd_pkg::result_t  result;
    chbd_pkg::kind_t    out_kind;
    chbd_pkg::cause_t   out_cause;
    logic [7:0]         out_data;
    logic               item_valid;
    logic               can_load;
    logic               advance;

    assign s_item.data = s_axis_tdata;
    assign s_item.sob  = s_axis_tuser[0];
    assign advance     = item_valid && can_load;

    chbd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    chbd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    chbd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (out_data),
        .m_kind   (out_kind),
        .m_cause  (out_cause)
    );

    assign m_axis_tdata = {6'd0, out_cause, out_data};
    assign m_axis_tuser = out_kind;

endmodule

>>> rtl/chbd_checker.sv
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module chbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined result kind");

    // A payload item carries no cause; an end item carries neither byte nor cause.
    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == chbd_pkg::KIND_PAYLOAD |->
            m_axis_tdata[15:8] == 8'd0)
        else $error("payload item with a cause");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == chbd_pkg::KIND_END |->
            m_axis_tdata == 16'd0)
        else $error("end item with data");

endmodule

bind http_chunked_body_decoder_core chbd_checker u_chbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
